>>> sv/pid_controller_dead_zone_core_macros.svh
// Assertion macros for the PID dead-zone controller.
// Each macro expects signals named clk and rst in the calling module.
// Assertions are removed when SYNTHESIS is defined.
`ifndef PID_CONTROLLER_DEAD_ZONE_CORE_MACROS_SVH
`define PID_CONTROLLER_DEAD_ZONE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define PDZ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define PDZ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PDZ_ASSERT_IMP(lbl, ante, cons, msg)
`define PDZ_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/pdz_pkg.sv
// Shared types, widths and constants for the PID dead-zone controller.
// Used by pdz_cfg, pdz_law and the top level.
package pdz_pkg;

  localparam int FRAC_BITS = 8;   // fraction bits of drive and integral
  localparam int GAIN_FRAC = 8;   // gains are Q8.8

  localparam int SHL = (FRAC_BITS >= GAIN_FRAC) ? FRAC_BITS - GAIN_FRAC : 0;
  localparam int SHR = (FRAC_BITS < GAIN_FRAC) ? GAIN_FRAC - FRAC_BITS : 0;

  localparam int IN_W    = 16;
  localparam int GAIN_W  = 16;
  localparam int ERR_W   = IN_W + 1;
  localparam int D1_W    = ERR_W + 1;
  localparam int D2_W    = ERR_W + 2;
  localparam int PA_W    = GAIN_W + D2_W;      // covers e, first and second difference
  localparam int PB_W    = GAIN_W + ERR_W;
  localparam int SA_W    = PA_W + SHL;
  localparam int SB_W    = PB_W + SHL;
  localparam int INT_W   = SB_W;
  localparam int INS_W   = INT_W + 1;
  localparam int DUTY_W  = 7;
  localparam int ILIM_W  = 8;
  localparam int DZ_W    = 16;
  localparam int DRV_W   = DUTY_W + FRAC_BITS + 1;
  localparam int SUM_W   = SA_W + 3;
  localparam int OUT_W   = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic             MODE_RST  = 1'b1;
  localparam logic [DZ_W-1:0]   DZ_RST    = DZ_W'(30);
  localparam logic [DUTY_W-1:0] DUTY_RST  = DUTY_W'(70);
  localparam logic [ILIM_W-1:0] ILIM_RST  = ILIM_W'(100);

  localparam logic MODE_INCR = 1'b0;
  localparam logic MODE_POS  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE = 3'd0,
    REG_KP   = 3'd1,
    REG_KI   = 3'd2,
    REG_KD   = 3'd3,
    REG_DZ   = 3'd4,
    REG_DUTY = 3'd5,
    REG_ILIM = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic                     mode;
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic [DZ_W-1:0]          dead_zone;
    logic [DUTY_W-1:0]        duty_limit;
    logic [ILIM_W-1:0]        integral_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] err_last;
    logic signed [ERR_W-1:0] err_prev;
    logic signed [DRV_W-1:0] drive;
    logic signed [INT_W-1:0] integ;
  } state_t;

endpackage

>>> sv/pdz_cfg.sv
// Configuration register bank for the PID dead-zone controller.
// Depends on pdz_pkg for register indexes, reset values and cfg_t.
module pdz_cfg import pdz_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= MODE_RST;
      cfg.kp             <= '0;
      cfg.ki             <= '0;
      cfg.kd             <= '0;
      cfg.dead_zone      <= DZ_RST;
      cfg.duty_limit     <= DUTY_RST;
      cfg.integral_limit <= ILIM_RST;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_MODE: cfg.mode           <= cfg_data[0];
        REG_KP:   cfg.kp             <= $signed(cfg_data[GAIN_W-1:0]);
        REG_KI:   cfg.ki             <= $signed(cfg_data[GAIN_W-1:0]);
        REG_KD:   cfg.kd             <= $signed(cfg_data[GAIN_W-1:0]);
        REG_DZ:   cfg.dead_zone      <= cfg_data[DZ_W-1:0];
        REG_DUTY: cfg.duty_limit     <= cfg_data[DUTY_W-1:0];
        REG_ILIM: cfg.integral_limit <= cfg_data[ILIM_W-1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

endmodule

>>> sv/pdz_law.sv
// Control law for one tick: error, dead zone, incremental or positional PID.
// Purely combinational; depends on pdz_pkg for cfg_t, state_t and widths.
module pdz_law import pdz_pkg::*; (
  input  logic signed [IN_W-1:0] target,
  input  logic signed [IN_W-1:0] measured,
  input  cfg_t                   cfg,
  input  state_t                 st,
  output state_t                 nxt,
  output logic                   dz
);

  logic signed [ERR_W-1:0] err;
  logic [ERR_W-1:0]        err_mag;
  logic signed [D1_W-1:0]  d1;
  logic signed [D2_W-1:0]  d2;
  logic signed [D2_W-1:0]  opa;
  logic signed [D2_W-1:0]  opc;
  logic signed [PA_W-1:0]  prod_a;
  logic signed [PB_W-1:0]  prod_b;
  logic signed [PA_W-1:0]  prod_c;
  logic signed [SA_W-1:0]  sa;
  logic signed [SB_W-1:0]  sb;
  logic signed [SA_W-1:0]  sc;
  logic [DRV_W-1:0]        drv_mag;
  logic [DRV_W-1:0]        dlim_u;
  logic                    windup_ok;
  logic signed [INS_W-1:0] ilim_s;
  logic signed [INS_W-1:0] integ_sum;
  logic signed [INT_W-1:0] integ_clamp;
  logic signed [INT_W-1:0] integ_pos;
  logic signed [SUM_W-1:0] dlim_s;
  logic signed [SUM_W-1:0] pos_sum;
  logic signed [SUM_W-1:0] inc_sum;
  logic signed [SUM_W-1:0] sum_sel;
  logic signed [DRV_W-1:0] drv_clamp;

  assign err     = ERR_W'(target) - ERR_W'(measured);
  assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign dz      = err_mag < {1'b0, cfg.dead_zone};

  assign d1 = D1_W'(err) - D1_W'(st.err_last);
  assign d2 = D2_W'(err) - (D2_W'(st.err_last) <<< 1) + D2_W'(st.err_prev);

  // Share three multipliers between the two modes
  assign opa = (cfg.mode == MODE_POS) ? D2_W'(err) : D2_W'(d1);
  assign opc = (cfg.mode == MODE_POS) ? D2_W'(d1) : d2;

  assign prod_a = PA_W'(cfg.kp) * PA_W'(opa);
  assign prod_b = PB_W'(cfg.ki) * PB_W'(err);
  assign prod_c = PA_W'(cfg.kd) * PA_W'(opc);

  // Rescale Q8 products to the drive fraction, flooring when narrowing
  assign sa = (SA_W'(prod_a) <<< SHL) >>> SHR;
  assign sb = (SB_W'(prod_b) <<< SHL) >>> SHR;
  assign sc = (SA_W'(prod_c) <<< SHL) >>> SHR;

  // Anti-windup for positional mode: integrate only while the last drive magnitude is below the limit
  assign drv_mag   = st.drive[DRV_W-1] ? DRV_W'(-st.drive) : DRV_W'(st.drive);
  assign dlim_u    = DRV_W'({cfg.duty_limit, {FRAC_BITS{1'b0}}});
  assign windup_ok = drv_mag < dlim_u;

  assign ilim_s    = INS_W'({cfg.integral_limit, {FRAC_BITS{1'b0}}});
  assign integ_sum = INS_W'(st.integ) + INS_W'(sb);

  always_comb begin
    if (integ_sum > ilim_s) begin
      integ_clamp = INT_W'(ilim_s);
    end else if (integ_sum < -ilim_s) begin
      integ_clamp = INT_W'(-ilim_s);
    end else begin
      integ_clamp = INT_W'(integ_sum);
    end
  end

  assign integ_pos = windup_ok ? integ_clamp : st.integ;

  assign pos_sum = SUM_W'(sa) + SUM_W'(integ_pos) + SUM_W'(sc);
  assign inc_sum = SUM_W'(st.drive) + SUM_W'(sa) + SUM_W'(sb) + SUM_W'(sc);
  assign sum_sel = (cfg.mode == MODE_POS) ? pos_sum : inc_sum;
  assign dlim_s  = SUM_W'({cfg.duty_limit, {FRAC_BITS{1'b0}}});

  always_comb begin
    if (sum_sel > dlim_s) begin
      drv_clamp = DRV_W'(dlim_s);
    end else if (sum_sel < -dlim_s) begin
      drv_clamp = DRV_W'(-dlim_s);
    end else begin
      drv_clamp = DRV_W'(sum_sel);
    end
  end

  always_comb begin
    nxt.err_last = err;
    nxt.err_prev = st.err_last;
    if (dz) begin
      nxt.drive = '0;
      nxt.integ = '0;
    end else if (cfg.mode == MODE_POS) begin
      nxt.drive = drv_clamp;
      nxt.integ = integ_pos;
    end else begin
      // incremental mode leaves this tick's Ki*e as the integral seed
      nxt.drive = drv_clamp;
      nxt.integ = INT_W'(sb);
    end
  end

endmodule

>>> sv/pid_controller_dead_zone_core.sv
// PID controller with dead zone; depends on pdz_pkg, pdz_cfg, pdz_law and the macro header.
// Each item is held in the input register, then its result is registered in the result
// register once that is free or draining. Throughput: one item per cycle unless the output
// stalls; the tick's law is one pass through pdz_law between the input register and the
// result register, which also updates state. Reset (synchronous, rst high): clears error
// history, drive, integral and both stage valids, and loads the register defaults.
`include "pid_controller_dead_zone_core_macros.svh"

module pid_controller_dead_zone_core import pdz_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,   // [15:0] target, [31:16] measured
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // [15:0] drive
  output logic [0:0]            m_axis_tuser    // [0] in_dead_zone
);

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  logic   dz_next;

  logic                   in_valid;
  logic signed [IN_W-1:0] in_target;
  logic signed [IN_W-1:0] in_measured;
  logic                   out_valid;
  logic [OUT_W-1:0]       out_drive;
  logic                   out_dz;

  logic                    in_accept;
  logic                    advance;
  logic signed [DRV_W-1:0] dlim_s;

  pdz_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pdz_law u_law (
    .target   (in_target),
    .measured (in_measured),
    .cfg      (cfg),
    .st       (st),
    .nxt      (st_next),
    .dz       (dz_next)
  );

  // Advance the held item when the result register is free or draining
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_target   <= $signed(s_axis_tdata[15:0]);
      in_measured <= $signed(s_axis_tdata[31:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        st        <= st_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_drive <= OUT_W'(st_next.drive);
      out_dz    <= dz_next;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_drive;
  assign m_axis_tuser[0] = out_dz;

  assign dlim_s = DRV_W'({cfg.duty_limit, {FRAC_BITS{1'b0}}});

  `PDZ_ASSERT_IMP(a_dz_zero_drive, out_valid && out_dz, out_drive == '0,
    "dead-zone result carries nonzero drive")
  `PDZ_ASSERT_NXT(a_dz_zero_integ, advance && dz_next, st.integ == '0,
    "integral not cleared in dead zone")
  `PDZ_ASSERT_NXT(a_drive_bound, advance,
    (st.drive <= $past(dlim_s)) && (st.drive >= -$past(dlim_s)),
    "drive state outside duty limit")
  `PDZ_ASSERT_NXT(a_out_hold, out_valid && !m_axis_tready,
    out_valid && $stable(out_drive) && $stable(out_dz),
    "stalled result changed")
  `PDZ_ASSERT_NXT(a_in_hold, in_valid && !advance,
    in_valid && $stable(in_target) && $stable(in_measured) && $stable(st),
    "held item or state changed while blocked")

endmodule
